>>> rtl/txc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txc_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package txc_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int TERMINALS   = 8;
  localparam int SCREEN_SIZE = ROWS * COLUMNS;
  localparam int TOTAL_CELLS = TERMINALS * SCREEN_SIZE;
  localparam int SCROLL_CELLS = SCREEN_SIZE - COLUMNS;

  localparam int ADDR_W = $clog2(TOTAL_CELLS);
  localparam int TIDX_W = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

  // field widths
  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;
  localparam int DIR_W  = 2;
  localparam int TERM_W = 3;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ATTR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, SPACE_CODE};

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SWITCH = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd5;

  // cursor directions
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_BLANK,
    ST_READ,
    ST_RESULT
  } state_t;

  // request to the address unit
  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] offset;
  } addr_req_t;

endpackage

>>> rtl/txc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txc interfaces
// request, result and attribute write channels of the console writer
// ----------------------------------------------------------------------------
interface txc_item_if;
  logic                       valid;
  logic                       ready;
  logic [txc_pkg::KIND_W-1:0] kind;
  logic [txc_pkg::CHAR_W-1:0] char_code;
  logic [txc_pkg::DIR_W-1:0]  direction;
  logic [txc_pkg::TERM_W-1:0] term_index;
  logic [txc_pkg::ROW_W-1:0]  read_row;
  logic [txc_pkg::COL_W-1:0]  read_col;

  modport source (output valid, kind, char_code, direction, term_index, read_row, read_col,
                  input ready);
  modport sink (input valid, kind, char_code, direction, term_index, read_row, read_col,
                output ready);
endinterface

interface txc_result_if;
  logic                       valid;
  logic                       ready;
  logic [txc_pkg::ROW_W-1:0]  cursor_row;
  logic [txc_pkg::COL_W-1:0]  cursor_col;
  logic [txc_pkg::TERM_W-1:0] active_term;
  logic [txc_pkg::CELL_W-1:0] cell_value;

  modport source (output valid, cursor_row, cursor_col, active_term, cell_value,
                  input ready);
  modport sink (input valid, cursor_row, cursor_col, active_term, cell_value,
                output ready);
endinterface

interface txc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [txc_pkg::ATTR_W-1:0] cell_attribute;

  modport source (output valid, cell_attribute, input ready);
  modport sink (input valid, cell_attribute, output ready);
endinterface

>>> rtl/txc_addr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txc_addr_unit
// shared cell address generator: terminal base plus row stride plus offset
// ----------------------------------------------------------------------------
module txc_addr_unit (
  input  txc_pkg::addr_req_t                req,
  output logic [txc_pkg::ADDR_W-1:0]        addr
);

  logic [txc_pkg::ADDR_W-1:0] term_base;
  logic [txc_pkg::ADDR_W-1:0] row_base;

  assign term_base = txc_pkg::ADDR_W'(req.term) * txc_pkg::ADDR_W'(txc_pkg::SCREEN_SIZE);
  assign row_base  = txc_pkg::ADDR_W'(req.row) * txc_pkg::ADDR_W'(txc_pkg::COLUMNS);
  assign addr      = term_base + row_base + req.offset;

endmodule

>>> rtl/txc_screen_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txc_screen_ram
// single port cell store of all terminals, registered read
// ----------------------------------------------------------------------------
module txc_screen_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [txc_pkg::ADDR_W-1:0]        addr,
  input  logic [txc_pkg::CELL_W-1:0]        wdata,
  output logic [txc_pkg::CELL_W-1:0]        rdata
);

  logic [txc_pkg::CELL_W-1:0] mem [txc_pkg::TOTAL_CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

>>> rtl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// character cell console over several virtual terminals
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | carries
//  ---------+-----+---------------+------------------------------------------
//  item     | in  | valid / ready | kind, char_code, direction, term_index,
//           |     |               | read_row, read_col
//  result   | out | valid / ready | cursor_row, cursor_col, active_term,
//           |     |               | cell_value
//  cfg      | in  | valid / ready | cell_attribute (always ready)
//
//  put, move, delete, switch, spare kinds, read off the screen: exec, then
//    the result state, which loads the result register
//  read cell: an extra read state for the registered read of the cell store
//  clear: one cell a cycle through the single ram port
//  scroll (newline or wrap on the bottom row): each moved cell needs a read
//    and a write slot
//  after reset a clearing pass over all TOTAL_CELLS (16000) cells blanks every
//    screen; item ready stays low meanwhile, attribute writes are taken
//  a result held back by the sink stalls the block in its result state
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic              clk,
  input  logic              rst,
  txc_item_if.sink          item,
  txc_result_if.source      result,
  txc_cfg_if.sink           cfg
);

  txc_pkg::state_t state, state_next;

  logic [txc_pkg::ADDR_W-1:0] cnt;

  // captured request
  logic [txc_pkg::KIND_W-1:0] op_kind;
  logic [txc_pkg::CHAR_W-1:0] op_char;
  logic [txc_pkg::DIR_W-1:0]  op_dir;
  logic [txc_pkg::TERM_W-1:0] op_term;
  logic [txc_pkg::ROW_W-1:0]  op_row;
  logic [txc_pkg::COL_W-1:0]  op_col;

  // per terminal cursors and active terminal
  logic [txc_pkg::ROW_W-1:0]  cur_rows [txc_pkg::TERMINALS];
  logic [txc_pkg::COL_W-1:0]  cur_cols [txc_pkg::TERMINALS];
  logic [txc_pkg::TERM_W-1:0] active;
  logic [txc_pkg::TIDX_W-1:0] act_idx;
  logic [txc_pkg::ATTR_W-1:0] attr;
  logic [txc_pkg::CELL_W-1:0] value;

  // output register
  logic                       res_valid;
  logic [txc_pkg::ROW_W-1:0]  res_row;
  logic [txc_pkg::COL_W-1:0]  res_col;
  logic [txc_pkg::TERM_W-1:0] res_term;
  logic [txc_pkg::CELL_W-1:0] res_value;

  // ram and address unit
  txc_pkg::addr_req_t         areq;
  logic [txc_pkg::ADDR_W-1:0] ram_addr;
  logic                       ram_we;
  logic [txc_pkg::CELL_W-1:0] ram_wdata;
  logic [txc_pkg::CELL_W-1:0] ram_rdata;

  // exec decode
  logic [txc_pkg::ROW_W-1:0]  cur_row;
  logic [txc_pkg::COL_W-1:0]  cur_col;
  logic [txc_pkg::ROW_W-1:0]  exec_row;
  logic [txc_pkg::COL_W-1:0]  exec_col;
  logic [txc_pkg::ROW_W-1:0]  exec_arow;
  logic [txc_pkg::COL_W-1:0]  exec_acol;
  logic                       exec_we;
  logic [txc_pkg::CELL_W-1:0] exec_wdata;
  txc_pkg::state_t            exec_next;
  logic [txc_pkg::ROW_W-1:0]  left_row;
  logic [txc_pkg::COL_W-1:0]  left_col;
  logic [txc_pkg::CELL_W-1:0] blank;
  logic                       out_free;

  assign act_idx  = active[txc_pkg::TIDX_W-1:0];
  assign cur_row  = cur_rows[act_idx];
  assign cur_col  = cur_cols[act_idx];
  assign blank    = {attr, txc_pkg::SPACE_CODE};
  assign out_free = !res_valid || result.ready;

  assign item.ready = (state == txc_pkg::ST_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid       = res_valid;
  assign result.cursor_row  = res_row;
  assign result.cursor_col  = res_col;
  assign result.active_term = res_term;
  assign result.cell_value  = res_value;

  txc_addr_unit u_addr (
    .req  (areq),
    .addr (ram_addr)
  );

  txc_screen_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // one step left, wrapping to the row above; stays at the top-left cell
  always_comb begin
    left_row = cur_row;
    left_col = cur_col;
    if (cur_col == '0) begin
      if (cur_row != '0) begin
        left_col = txc_pkg::COL_W'(txc_pkg::COLUMNS - 1);
        left_row = cur_row - 1'b1;
      end
    end else begin
      left_col = cur_col - 1'b1;
    end
  end

  // decode of the captured request against the active cursor
  always_comb begin
    exec_row   = cur_row;
    exec_col   = cur_col;
    exec_arow  = cur_row;
    exec_acol  = cur_col;
    exec_we    = 1'b0;
    exec_wdata = blank;
    exec_next  = txc_pkg::ST_RESULT;
    unique case (op_kind)
      txc_pkg::KIND_PUT: begin
        if (op_char != txc_pkg::NEWLINE_CODE) begin
          exec_we    = 1'b1;
          exec_wdata = {attr, op_char};
        end
        // newline or the last column filled: go to the next line
        if (op_char == txc_pkg::NEWLINE_CODE ||
            cur_col == txc_pkg::COL_W'(txc_pkg::COLUMNS - 1)) begin
          exec_col = '0;
          if (cur_row == txc_pkg::ROW_W'(txc_pkg::ROWS - 1)) begin
            exec_next = txc_pkg::ST_SCROLL_RD;
          end else begin
            exec_row = cur_row + 1'b1;
          end
        end else begin
          exec_col = cur_col + 1'b1;
        end
      end
      txc_pkg::KIND_MOVE: begin
        unique case (op_dir)
          txc_pkg::DIR_UP: begin
            if (cur_row != '0) begin
              exec_row = cur_row - 1'b1;
            end
          end
          txc_pkg::DIR_DOWN: begin
            if (cur_row != txc_pkg::ROW_W'(txc_pkg::ROWS - 1)) begin
              exec_row = cur_row + 1'b1;
            end
          end
          txc_pkg::DIR_LEFT: begin
            exec_row = left_row;
            exec_col = left_col;
          end
          default: begin
            if (cur_col == txc_pkg::COL_W'(txc_pkg::COLUMNS - 1)) begin
              if (cur_row != txc_pkg::ROW_W'(txc_pkg::ROWS - 1)) begin
                exec_col = '0;
                exec_row = cur_row + 1'b1;
              end
            end else begin
              exec_col = cur_col + 1'b1;
            end
          end
        endcase
      end
      txc_pkg::KIND_DELETE: begin
        exec_row  = left_row;
        exec_col  = left_col;
        exec_arow = left_row;
        exec_acol = left_col;
        exec_we   = 1'b1;
      end
      txc_pkg::KIND_CLEAR: begin
        exec_next = txc_pkg::ST_BLANK;
      end
      txc_pkg::KIND_READ: begin
        exec_arow = op_row;
        exec_acol = op_col;
        // outside the screen reads as zero without touching the store
        if (32'(op_row) < txc_pkg::ROWS && 32'(op_col) < txc_pkg::COLUMNS) begin
          exec_next = txc_pkg::ST_READ;
        end
      end
      default: begin
        exec_next = txc_pkg::ST_RESULT;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      txc_pkg::ST_INIT: begin
        if (cnt == txc_pkg::ADDR_W'(txc_pkg::TOTAL_CELLS - 1)) begin
          state_next = txc_pkg::ST_IDLE;
        end
      end
      txc_pkg::ST_IDLE: begin
        if (item.valid) begin
          state_next = txc_pkg::ST_EXEC;
        end
      end
      txc_pkg::ST_EXEC: begin
        state_next = exec_next;
      end
      txc_pkg::ST_SCROLL_RD: begin
        state_next = txc_pkg::ST_SCROLL_WR;
      end
      txc_pkg::ST_SCROLL_WR: begin
        if (cnt == txc_pkg::ADDR_W'(txc_pkg::SCROLL_CELLS - 1)) begin
          state_next = txc_pkg::ST_BLANK;
        end else begin
          state_next = txc_pkg::ST_SCROLL_RD;
        end
      end
      txc_pkg::ST_BLANK: begin
        if (cnt == txc_pkg::ADDR_W'(txc_pkg::SCREEN_SIZE - 1)) begin
          state_next = txc_pkg::ST_RESULT;
        end
      end
      txc_pkg::ST_READ: begin
        state_next = txc_pkg::ST_RESULT;
      end
      txc_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = txc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = txc_pkg::ST_INIT;
      end
    endcase
  end

  // address unit and ram control
  always_comb begin
    areq.term   = active;
    areq.row    = '0;
    areq.offset = cnt;
    ram_we      = 1'b0;
    ram_wdata   = blank;
    unique case (state)
      txc_pkg::ST_INIT: begin
        areq.term = '0;
        ram_we    = 1'b1;
        ram_wdata = txc_pkg::RESET_CELL;
      end
      txc_pkg::ST_EXEC: begin
        areq.row    = exec_arow;
        areq.offset = txc_pkg::ADDR_W'(exec_acol);
        ram_we      = exec_we;
        ram_wdata   = exec_wdata;
      end
      txc_pkg::ST_SCROLL_RD: begin
        // fetch the cell one row below
        areq.offset = cnt + txc_pkg::ADDR_W'(txc_pkg::COLUMNS);
      end
      txc_pkg::ST_SCROLL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      txc_pkg::ST_BLANK: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      unique case (state) inside
        txc_pkg::ST_INIT, txc_pkg::ST_BLANK: begin
          cnt <= cnt + 1'b1;
        end
        txc_pkg::ST_EXEC: begin
          cnt <= '0;
        end
        txc_pkg::ST_SCROLL_WR: begin
          if (cnt == txc_pkg::ADDR_W'(txc_pkg::SCROLL_CELLS - 1)) begin
            cnt <= txc_pkg::ADDR_W'(txc_pkg::SCROLL_CELLS);
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  // state, cursors and active terminal
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= txc_pkg::ST_INIT;
      active <= '0;
      for (int t = 0; t < txc_pkg::TERMINALS; t++) begin
        cur_rows[t] <= '0;
        cur_cols[t] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == txc_pkg::ST_EXEC) begin
        cur_rows[act_idx] <= exec_row;
        cur_cols[act_idx] <= exec_col;
        if (op_kind == txc_pkg::KIND_SWITCH && 32'(op_term) < txc_pkg::TERMINALS) begin
          active <= op_term;
        end
      end
    end
  end

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= txc_pkg::RESET_ATTR;
    end else if (cfg.valid) begin
      attr <= cfg.cell_attribute;
    end
  end

  // request capture and read value
  always_ff @(posedge clk) begin
    if (state == txc_pkg::ST_IDLE && item.valid) begin
      op_kind <= item.kind;
      op_char <= item.char_code;
      op_dir  <= item.direction;
      op_term <= item.term_index;
      op_row  <= item.read_row;
      op_col  <= item.read_col;
    end
    if (state == txc_pkg::ST_EXEC) begin
      value <= '0;
    end else if (state == txc_pkg::ST_READ) begin
      value <= ram_rdata;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == txc_pkg::ST_RESULT && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == txc_pkg::ST_RESULT && out_free) begin
      res_row   <= cur_row;
      res_col   <= cur_col;
      res_term  <= active;
      res_value <= value;
    end
  end

endmodule

>>> rtl/txc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txc_checker
// port level checks of the text console writer
// ----------------------------------------------------------------------------
module txc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [txc_pkg::ROW_W-1:0]  out_row,
  input logic [txc_pkg::COL_W-1:0]  out_col,
  input logic [txc_pkg::TERM_W-1:0] out_term,
  input logic [txc_pkg::CELL_W-1:0] out_value
);

  // a request occupies the block: no second accept right after one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item ready right after an accepted request");

  // reset starts the clearing pass, so no request is taken next
  a_reset_not_ready: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item ready right after reset");

  // reported cursor and terminal stay on the screen
  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_row) < txc_pkg::ROWS) && (32'(out_col) < txc_pkg::COLUMNS)
                  && (32'(out_term) < txc_pkg::TERMINALS))
    else $error("result cursor or terminal out of range");

  // a held result keeps its payload
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
                                && $stable(out_term) && $stable(out_value))
    else $error("stalled result changed");

endmodule

bind text_console_writer txc_checker u_txc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_row   (result.cursor_row),
  .out_col   (result.cursor_col),
  .out_term  (result.active_term),
  .out_value (result.cell_value)
);
